// ===== src/substring_occurrence_finder_macros.svh =====
// Assertion macros for the substring occurrence finder.
`ifndef SUBSTRING_OCCURRENCE_FINDER_MACROS_SVH
`define SUBSTRING_OCCURRENCE_FINDER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SOF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("substring finder: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SOF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("substring finder: next-cycle check failed");

`endif

// ===== src/sof_pkg.sv =====
// Shared constants and types of the substring occurrence finder.
`default_nettype none

package sof_pkg;

    localparam int MAX_PATTERN  = 8;
    localparam int MAX_TEXT     = 256;
    localparam int BYTE_W       = 8;
    localparam int POS_W        = $clog2(MAX_TEXT + 1);
    localparam int PAT_BYTES_W  = 64;
    localparam int PAT_LEN_W    = 4;
    localparam int START_W      = 8;

    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 5;
    localparam int REG_SEL_LSB  = 3;
    localparam int REG_SEL_W    = APB_ADDR_W - REG_SEL_LSB;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REG_SEL_W-1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_START_POSITION = 2'd2
    } reg_sel_t;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef byte_t [MAX_PATTERN-1:0] window_t;

    // One classified word: window after the shift, its text index, last mark.
    typedef struct packed {
        window_t          window;
        logic [POS_W-1:0] position;
        logic             last;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_port_t;

    typedef struct packed {
        logic [PAT_BYTES_W-1:0] pattern_bytes;
        logic [PAT_LEN_W-1:0]   pattern_length;
        logic [START_W-1:0]     start_position;
    } cfg_t;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic               last;
        logic               over;
    } result_t;

endpackage

`default_nettype wire

// ===== src/sof_front.sv =====
// Front end: accepts text words, keeps the byte window and text position.
`default_nettype none

module sof_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [sof_pkg::BYTE_W-1:0] text_byte,
    input  wire logic                    is_last,
    input  wire logic                    push,
    input  wire logic                    full,
    output sof_pkg::q_port_t             wr
);
    import sof_pkg::*;

    window_t          window_reg, window_next, shifted;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             accept;
    logic             over;

    assign accept = push && !full;
    assign over   = pos_reg >= POS_W'(MAX_TEXT);

    always_comb
    begin
        shifted[0] = text_byte;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            shifted[i] = window_reg[i-1];
        end
    end

    always_comb
    begin
        window_next = window_reg;
        pos_next    = pos_reg;
        if (accept)
        begin
            if (is_last)
            begin
                window_next = '0;
                pos_next    = '0;
            end
            else
            begin
                window_next = shifted;
                if (!over)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
        end
    end

    assign wr.valid         = push;
    assign wr.item.window   = shifted;
    assign wr.item.position = pos_reg;
    assign wr.item.last     = is_last;

endmodule

`default_nettype wire

// ===== src/sof_queue.sv =====
// Short queue between the front end and the matcher.
`default_nettype none

module sof_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sof_pkg::q_port_t wr,
    output logic            full,
    input  wire logic       rd,
    output sof_pkg::q_port_t head
);
    import sof_pkg::*;

    item_t                  store_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   wr_en, rd_en;

    assign full  = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign wr_en = wr.valid && !full;
    assign rd_en = rd && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr.item;
        end
    end

    assign head.valid = count_reg != '0;
    assign head.item  = store_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== src/sof_back.sv =====
// Back end: window compare against the pattern and result register.
`default_nettype none

module sof_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sof_pkg::cfg_t    cfg,
    input  wire sof_pkg::q_port_t head,
    output logic             rd,
    input  wire logic        pop,
    output logic             empty,
    output sof_pkg::result_t result
);
    import sof_pkg::*;

    logic               out_valid_reg, out_valid_next;
    result_t            result_reg, result_next;
    logic               over;
    logic               same;
    logic               hit;
    logic [POS_W:0]     pos_plus;
    logic [POS_W:0]     len_ext;
    logic [POS_W:0]     start;
    logic               long_enough;
    logic               start_ok;
    logic               found;

    assign over     = head.item.position >= POS_W'(MAX_TEXT);
    assign pos_plus = {1'b0, head.item.position} + (POS_W+1)'(1);
    assign len_ext  = (POS_W+1)'(cfg.pattern_length);
    assign long_enough = pos_plus >= len_ext;
    assign start    = pos_plus - len_ext;
    assign start_ok = start >= (POS_W+1)'(cfg.start_position);

    // Per-length compare; newest byte sits at window entry 0.
    always_comb
    begin
        same = 1'b0;
        hit  = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            hit = 1'b1;
            for (int k = 0; k < l; k++)
            begin
                if (head.item.window[l-1-k] != cfg.pattern_bytes[BYTE_W*k +: BYTE_W])
                begin
                    hit = 1'b0;
                end
            end
            if (cfg.pattern_length == PAT_LEN_W'(l))
            begin
                same = hit;
            end
        end
    end

    assign found = !over && long_enough && same && start_ok;

    assign rd = head.valid && (!out_valid_reg || pop);

    always_comb
    begin
        result_next.found = found;
        result_next.start = found ? start[START_W-1:0] : '0;
        result_next.last  = head.item.last;
        result_next.over  = over;
        out_valid_next    = out_valid_reg;
        if (rd)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            result_reg <= result_next;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/substring_occurrence_finder.sv =====
// An accepted word is registered in the queue and then in the result register.
// Throughput: one text word per cycle while full is low; the front end, a two-entry
// queue and the result register let push and pop stall independently.
// Reset (rst_n low, asynchronous): registers, byte window and position to zero,
// queue and result register empty.
`default_nettype none

`include "substring_occurrence_finder_macros.svh"

module substring_occurrence_finder (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // text words in
    input  wire logic [sof_pkg::BYTE_W-1:0]      text_byte,
    input  wire logic                            is_last,
    input  wire logic                            push,
    output logic                                 full,
    // result words out
    output logic                                 match_found,
    output logic [sof_pkg::START_W-1:0]          match_start,
    output logic                                 end_of_text,
    output logic                                 overflow,
    output logic                                 empty,
    input  wire logic                            pop,
    // register port, 8-byte stride
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sof_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [sof_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sof_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import sof_pkg::*;

    // Register file. Writes are only expected while the block is idle,
    // so the matcher reads these directly.
    logic [PAT_BYTES_W-1:0] pattern_bytes_reg;
    logic [PAT_LEN_W-1:0]   pattern_length_reg;
    logic [START_W-1:0]     start_position_reg;
    logic                   cfg_write;
    reg_sel_t               reg_sel;
    cfg_t                   cfg;

    q_port_t                q_wr;
    q_port_t                q_head;
    logic                   q_full;
    logic                   q_rd;
    result_t                result;

    assign pready    = 1'b1;
    assign reg_sel   = reg_sel_t'(paddr[APB_ADDR_W-1:REG_SEL_LSB]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= '0;
            start_position_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= pwdata[PAT_BYTES_W-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= pwdata[PAT_LEN_W-1:0];
                REG_START_POSITION: start_position_reg <= pwdata[START_W-1:0];
                default:            ;
            endcase
        end
    end

    // Readback, zero-extended; unmapped slots read as zero.
    always_comb
    begin
        case (reg_sel)
            REG_PATTERN_BYTES:  prdata = APB_DATA_W'(pattern_bytes_reg);
            REG_PATTERN_LENGTH: prdata = APB_DATA_W'(pattern_length_reg);
            REG_START_POSITION: prdata = APB_DATA_W'(start_position_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.pattern_bytes  = pattern_bytes_reg;
    assign cfg.pattern_length = pattern_length_reg;
    assign cfg.start_position = start_position_reg;

    // Front end: takes a word whenever the queue has room, shifts the window and advances
    // the position (saturating at MAX_TEXT); a word with the last mark clears both instead.
    sof_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (text_byte),
        .is_last   (is_last),
        .push      (push),
        .full      (q_full),
        .wr        (q_wr)
    );

    // Two-entry decoupling queue; full here is full at the port.
    sof_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .rd    (q_rd),
        .head  (q_head)
    );

    // Back end: compares the window against the pattern and holds the
    // result word until it is popped; refills in the same cycle as a pop.
    sof_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .head   (q_head),
        .rd     (q_rd),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

    assign full        = q_full;
    assign match_found = result.found;
    assign match_start = result.start;
    assign end_of_text = result.last;
    assign overflow    = result.over;

    // A text beyond the supported length never matches.
    `SOF_ASSERT_SAME(a_no_match_on_overflow, !empty && overflow, !match_found)
    // Start index is only meaningful with a match.
    `SOF_ASSERT_SAME(a_start_zero_without_match, !empty && !match_found, match_start == '0)
    // An accepted word is in the queue on the next cycle.
    `SOF_ASSERT_NEXT(a_accept_lands_in_queue, push && !full, q_head.valid)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the substring occurrence finder: random and directed text streams.
`default_nettype none

module testbench;

    import sof_pkg::*;

    // Cycles with no accepted word, result or register write before the run is abandoned.
    // The limit is ample for the slowest phase, which idles the sender 82 times in a hundred,
    // and for the receiver's long hold-off.
    localparam int QUIET_LIMIT    = 3000;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES    = 8;

    // One text word as the sender offers it.
    typedef struct packed {
        byte_t ch;
        logic  last;
    } text_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  push      = 1'b0;
    logic [BYTE_W-1:0]     text_byte = '0;
    logic                  is_last   = 1'b0;
    logic                  full;

    logic                  match_found;
    logic [START_W-1:0]    match_start;
    logic                  end_of_text;
    logic                  overflow;
    logic                  empty;
    logic                  pop       = 1'b0;

    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    substring_occurrence_finder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_byte   (text_byte),
        .is_last     (is_last),
        .push        (push),
        .full        (full),
        .match_found (match_found),
        .match_start (match_start),
        .end_of_text (end_of_text),
        .overflow    (overflow),
        .empty       (empty),
        .pop         (pop),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------
    text_word_t pending_words[$];     // words still to be offered, oldest first
    result_t    awaited_results[$];   // predicted result words, oldest first

    // Copy of the search registers, updated when a write lands on the port.
    cfg_t              search_cfg = '0;
    // Copy of the byte window (entry 0 newest) and the index of the next byte.
    window_t           text_window = '0;
    logic [POS_W-1:0]  text_pos    = '0;

    // Pattern as last programmed; the text generator plants it in the stream.
    logic [63:0] cur_pattern = '0;
    int          cur_len     = 0;

    int  tx_idle_pct   = 0;  // chance in a hundred that the sender skips a cycle
    int  rx_stall_pct  = 0;  // chance in a hundred that the receiver refuses a word
    int  hold_requests = 0;  // bumped to ask the receiver for one long hold-off
    bit  word_taken    = 1'b0;
    int  mismatches    = 0;
    int  quiet_cycles  = 0;

    // ------------------------------------------------------------------
    // Prediction: the search applied to one accepted text word
    // ------------------------------------------------------------------
    function automatic result_t scan_text_byte(byte_t ch, logic last);
        result_t r;
        int      here;
        int      len;
        int      first;
        logic    over;
        logic    same;
        here = int'(text_pos);
        len  = int'(search_cfg.pattern_length);
        over = (here >= MAX_TEXT);
        for (int i = MAX_PATTERN - 1; i > 0; i--)
            text_window[i] = text_window[i - 1];
        text_window[0] = ch;
        r      = '0;
        r.last = last;
        r.over = over;
        // Empty or over-long patterns, bytes past the text limit and a text still
        // shorter than the pattern can never match.
        if (!over && len != 0 && len <= MAX_PATTERN && here + 1 >= len)
        begin
            same = 1'b1;
            // Oldest byte of the candidate lies len-1 places back in the window.
            for (int k = 0; k < len; k++)
                if (text_window[len - 1 - k] != search_cfg.pattern_bytes[8 * k +: 8])
                    same = 1'b0;
            first = here + 1 - len;
            if (same && first >= int'(search_cfg.start_position))
            begin
                r.found = 1'b1;
                r.start = START_W'(first);
            end
        end
        // Last mark starts a fresh text; otherwise the index saturates at the limit.
        if (last)
        begin
            text_pos    = '0;
            text_window = '0;
        end
        else if (!over)
            text_pos = POS_W'(here + 1);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both handshakes and the register port at the rising
    // edge, predicts on every accepted text word, checks every result word,
    // and runs the watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t want;
        logic    busy;
        word_taken = 1'b0;
        busy       = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                awaited_results.push_back(scan_text_byte(text_byte, is_last));
                word_taken = 1'b1;
                busy       = 1'b1;
            end
            if (pop && !empty)
            begin
                busy = 1'b1;
                if (awaited_results.size() == 0)
                    report_mismatch("result word with none awaited", match_found, 0);
                else
                begin
                    want = awaited_results.pop_front();
                    compare_field("match_found", match_found, want.found);
                    compare_field("match_start", match_start, want.start);
                    compare_field("end_of_text", end_of_text, want.last);
                    compare_field("overflow", overflow, want.over);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                busy = 1'b1;
                // Bits above a register's width are dropped, as in the block.
                case (reg_sel_t'(paddr[APB_ADDR_W-1:REG_SEL_LSB]))
                    REG_PATTERN_BYTES:  search_cfg.pattern_bytes  = pwdata;
                    REG_PATTERN_LENGTH: search_cfg.pattern_length = pwdata[PAT_LEN_W-1:0];
                    REG_START_POSITION: search_cfg.start_position = pwdata[START_W-1:0];
                    default: ;
                endcase
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t watchdog: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: offers the oldest pending word at the falling edge, idling at
    // random; a word leaves the queue once the monitor saw it taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : sender
        if (rst_n)
        begin
            if (word_taken)
                void'(pending_words.pop_front());
            if (pending_words.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct)
            begin
                push      <= 1'b1;
                text_byte <= pending_words[0].ch;
                is_last   <= pending_words[0].last;
            end
            else
                push <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: pops at random; on request it holds off for a long stretch,
    // counted here, so the block backs up and raises full.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : receiver
        int hold_seen;
        int hold_left;
        if (rst_n)
        begin
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99, 0) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Register writes: setup then access; back-to-back writes keep psel high.
    // ------------------------------------------------------------------
    task automatic write_register(input reg_sel_t sel, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, {REG_SEL_LSB{1'b0}}};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // Programs all three registers; junk above the narrow fields must be ignored.
    task automatic program_search(input logic [63:0] pat, input int len, input int start);
        logic [63:0] junk;
        write_register(REG_PATTERN_BYTES, pat);
        junk = {$urandom, $urandom};
        junk[PAT_LEN_W-1:0] = PAT_LEN_W'(len);
        write_register(REG_PATTERN_LENGTH, junk);
        junk = {$urandom, $urandom};
        junk[START_W-1:0] = START_W'(start);
        write_register(REG_START_POSITION, junk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_pattern = pat;
        cur_len     = len;
    endtask

    task automatic queue_word(input byte_t ch, input logic last);
        text_word_t w;
        w.ch   = ch;
        w.last = last;
        pending_words.push_back(w);
    endtask

    // n copies of one byte as a single text.
    task automatic queue_repeat(input byte_t ch, input int n);
        for (int j = 0; j < n; j++)
            queue_word(ch, j == n - 1);
    endtask

    // Random search settings: mostly usable lengths, sometimes empty or too long;
    // half the patterns from two symbols so that they overlap themselves.
    task automatic random_search_setup();
        logic [63:0] pat;
        byte_t       sym_a;
        byte_t       sym_b;
        int          len;
        int          start;
        sym_a = byte_t'($urandom);
        sym_b = byte_t'($urandom);
        pat   = {$urandom, $urandom};
        if ($urandom_range(1, 0))
            for (int k = 0; k < MAX_PATTERN; k++)
                pat[8 * k +: 8] = $urandom_range(1, 0) ? sym_a : sym_b;
        case ($urandom_range(9, 0))
            0:       len = 0;
            1:       len = $urandom_range(15, MAX_PATTERN + 1);
            default: len = $urandom_range(MAX_PATTERN, 1);
        endcase
        case ($urandom_range(5, 0))
            0:       start = 255;
            1:       start = $urandom_range(30, 5);
            default: start = $urandom_range(3, 0);
        endcase
        program_search(pat, len, start);
    endtask

    // Texts of random length with the current pattern planted often, a few
    // planted only in part, the rest pattern bytes and arbitrary bytes mixed.
    task automatic queue_random_texts(input int budget);
        int    made;
        int    span;
        int    usable;
        int    plant_left;
        int    plant_idx;
        int    pick;
        byte_t ch;
        made   = 0;
        usable = (cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len;
        while (made < budget)
        begin
            span       = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 17)
                                                     : $urandom_range(16, 1);
            plant_left = 0;
            plant_idx  = 0;
            for (int j = 0; j < span; j++)
            begin
                if (plant_left == 0 && usable != 0 && $urandom_range(3, 0) == 0)
                begin
                    plant_left = ($urandom_range(5, 0) == 0) ? $urandom_range(usable, 1)
                                                             : usable;
                    plant_idx  = 0;
                end
                if (plant_left != 0)
                begin
                    ch = cur_pattern[8 * plant_idx +: 8];
                    plant_idx++;
                    plant_left--;
                end
                else if ($urandom_range(1, 0))
                begin
                    pick = $urandom_range(MAX_PATTERN - 1, 0);
                    ch   = cur_pattern[8 * pick +: 8];
                end
                else
                    ch = byte_t'($urandom);
                queue_word(ch, j == span - 1);
            end
            made += span;
        end
    endtask

    // Every offered word accepted and every predicted result word popped.
    task automatic wait_until_drained();
        while (pending_words.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: overlapping hits of "aba", then a short text that would only
        // match by borrowing the previous text's last byte.
        program_search(64'h0000_0000_0061_6261, 3, 0);
        queue_word(8'h61, 1'b0);
        queue_word(8'h62, 1'b0);
        queue_word(8'h61, 1'b0);
        queue_word(8'h62, 1'b0);
        queue_word(8'h61, 1'b1);
        queue_word(8'h62, 1'b0);
        queue_word(8'h61, 1'b1);
        wait_until_drained();
        // Empty pattern over bytes that equal the pattern register.
        program_search(64'h0, 0, 0);
        queue_repeat(8'h00, 2);
        wait_until_drained();
        // Pattern longer than the window.
        program_search(64'h0, 15, 0);
        queue_repeat(8'h00, 2);
        wait_until_drained();
        // Hits below the start position are suppressed.
        program_search(64'h0, 1, 2);
        queue_repeat(8'h00, 4);
        wait_until_drained();
        // Full-width pattern of all ones, two overlapping hits.
        program_search(64'hFFFF_FFFF_FFFF_FFFF, MAX_PATTERN, 0);
        queue_repeat(8'hFF, MAX_PATTERN + 1);
        wait_until_drained();

        // Random phases, two settings per idling style.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph / 2)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 82; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 82; end
                default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
            endcase
            random_search_setup();
            if (ph == 6)
                hold_requests++;   // receiver backs off while the sender keeps going
            if (ph == 7)
            begin
                // Sender pauses mid-phase until every result word is home.
                queue_random_texts(18);
                wait_until_drained();
                queue_random_texts(17);
            end
            else
                queue_random_texts(35);
            wait_until_drained();

            if (ph == 3)
            begin
                // One text past the length limit: hits up to index 255, none once
                // overflow is up, then the next text starts again from zero.
                tx_idle_pct  = 22;
                rx_stall_pct = 22;
                program_search({$urandom, 24'h0, 8'h78}, 1, 250);
                for (int j = 0; j < MAX_TEXT + 6; j++)
                    queue_word((j >= 244 ? ($urandom_range(3, 0) != 0)
                                         : ($urandom_range(7, 0) == 0))
                               ? 8'h78 : byte_t'($urandom),
                               j == MAX_TEXT + 5);
                wait_until_drained();
            end
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch("result words never delivered", awaited_results.size(), 0);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== substring_occurrence_finder.f =====
+incdir+src
src/sof_pkg.sv
src/sof_front.sv
src/sof_queue.sv
src/sof_back.sv
src/substring_occurrence_finder.sv
dv/testbench.sv
